>>> src/stable_sorted_priority_queue_top_defines.svh
// Assertion macros for the stable sorted priority queue.
// Included by the top level; depends on nothing else.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSQ_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SSQ_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ssq_pkg.sv
// Types and codes shared by the stable sorted priority queue.
// Used by ssq_cell and stable_sorted_priority_queue_top; no dependencies.
`default_nettype none

package ssq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] process_id;
    logic [7:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       out_valid;
    logic [7:0] out_process_id;
    logic [7:0] out_priority;
    logic [4:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [7:0] pid;
    logic [7:0] pri;
  } entry_t;

  // Broadcast from the top level to every cell in a cycle.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } ctl_t;

endpackage

`default_nettype wire

>>> src/stable_sorted_priority_queue_top.sv
// The done strobe and its result appear in the cycle after an accepted start.
// Throughput: one operation per cycle; busy is tied low, and the cell chain
// updates every slot in parallel for each enqueue or dequeue.
// Reset (rst, synchronous, active high) empties the queue; slot payloads
// are not cleared, only their valid bits.
// The receiver cannot stall: each result shows for exactly one cycle.
// Depends on ssq_pkg, ssq_cell and the assertion macro header.
`default_nettype none
`include "stable_sorted_priority_queue_top_defines.svh"

module stable_sorted_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ssq_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output ssq_pkg::rsp_t      rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  ssq_pkg::entry_t  ents [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] shift;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  ssq_pkg::ctl_t    ctl;
  ssq_pkg::rsp_t    rsp_next;
  logic             accept;
  logic             full;
  logic             empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    ctl.enq     = accept && (cmd.operation == ssq_pkg::OP_ENQ) && !full;
    ctl.deq     = accept && (cmd.operation == ssq_pkg::OP_DEQ) && !empty;
    ctl.ent.pid = cmd.process_id;
    ctl.ent.pri = cmd.priority_req;
  end

  always_comb begin
    count_next              = count;
    rsp_next.status         = ssq_pkg::ST_DONE;
    rsp_next.out_valid      = 1'b0;
    rsp_next.out_process_id = '0;
    rsp_next.out_priority   = '0;
    if (cmd.operation == ssq_pkg::OP_ENQ) begin
      if (full) begin
        rsp_next.status = ssq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        rsp_next.status = ssq_pkg::ST_EMPTY;
      end else begin
        count_next              = count - CW'(1);
        rsp_next.out_valid      = 1'b1;
        rsp_next.out_process_id = ents[0].pid;
        rsp_next.out_priority   = ents[0].pri;
      end
    end
    rsp_next.occupancy = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssq_pkg::entry_t l_ent;
    logic            l_valid;
    logic            l_shift;
    ssq_pkg::entry_t r_ent;
    logic            r_valid;

    if (i == 0) begin : g_head
      // The head has a virtual left neighbor that always stays in place.
      assign l_ent   = ents[0];
      assign l_valid = 1'b1;
      assign l_shift = 1'b0;
    end else begin : g_body
      assign l_ent   = ents[i-1];
      assign l_valid = valid[i-1];
      assign l_shift = shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_ent   = ents[i];
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_ent   = ents[i+1];
      assign r_valid = valid[i+1];
    end

    ssq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_ent    (l_ent),
      .left_valid  (l_valid),
      .left_shift  (l_shift),
      .right_ent   (r_ent),
      .right_valid (r_valid),
      .ent         (ents[i]),
      .valid       (valid[i]),
      .shift       (shift[i])
    );
  end

  `SSQ_ASSERT_IMP(a_count_matches_valid, clk, rst, 1'b1, $countones(valid) == int'(count), "entry count disagrees with valid bits")
  `SSQ_ASSERT_NXT(a_done_follows_start, clk, rst, accept, done, "accepted beat produced no result")
  `SSQ_ASSERT_IMP(a_valid_means_done, clk, rst, done && rsp.out_valid, rsp.status == ssq_pkg::ST_DONE, "returned entry with error status")
  `SSQ_ASSERT_NXT(a_full_drop, clk, rst, accept && (cmd.operation == ssq_pkg::OP_ENQ) && full, (rsp.status == ssq_pkg::ST_FULL) && $stable(valid), "enqueue into full queue not dropped")

endmodule

`default_nettype wire

>>> src/ssq_cell.sv
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on ssq_pkg for the entry and control types.
`default_nettype none

module ssq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ssq_pkg::ctl_t   ctl,
  input  wire ssq_pkg::entry_t left_ent,
  input  wire logic            left_valid,
  input  wire logic            left_shift,
  input  wire ssq_pkg::entry_t right_ent,
  input  wire logic            right_valid,
  output ssq_pkg::entry_t      ent,
  output logic                 valid,
  output logic                 shift
);

  logic left_keep;

  // A held entry of higher priority value than the new one moves one place right.
  assign shift     = valid && (ent.pri > ctl.ent.pri);
  // The new entry lands in the cell whose left neighbor stays put and which is empty or moving right.
  assign left_keep = left_valid && !left_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.deq) begin
      valid <= right_valid;
    end else if (ctl.enq && (left_shift || (left_keep && (!valid || shift)))) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.deq) begin
      ent <= right_ent;
    end else if (ctl.enq) begin
      if (left_shift) begin
        ent <= left_ent;
      end else if (left_keep && (!valid || shift)) begin
        ent <= ctl.ent;
      end
    end
  end

endmodule

`default_nettype wire
